>>> src/lru_expert_slot_cache_unit_assert.svh
// Assertion macros shared by the checker of the expert slot cache.
`ifndef LRU_EXPERT_SLOT_CACHE_UNIT_ASSERT_SVH
`define LRU_EXPERT_SLOT_CACHE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LESC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle rule violated");

// Consequent must hold in the cycle after the antecedent.
`define LESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle rule violated");

`endif

>>> src/lesc_pkg.sv
// Shared types, codes and helpers of the expert slot cache.
package lesc_pkg;

    // Default sizes
    localparam int LAYERS_DEF  = 16;
    localparam int SLOTS_DEF   = 8;
    localparam int EXPERTS_DEF = 64;

    // Fixed field widths
    localparam int OP_W  = 2;
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_SLOTS_RESET = 4'd8;

    // Operation codes
    typedef logic [OP_W-1:0] op_code_t;
    localparam op_code_t OP_ACCESS = 2'd0;
    localparam op_code_t OP_PEEK   = 2'd1;
    localparam op_code_t OP_CLEAR  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the request beat and read the layer row
        logic commit;    // write the row back and load the result beat
    } lesc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // result register can take a new beat
    } lesc_stat_t;

    // Index width with a floor of one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> src/lru_expert_slot_cache_unit.sv
// A request is latched as its row is read; ST_EXEC commits once the result register is free.
// A new request waits until the last one commits: the layer row is read, then written back.
// The row store has one read and one write port; the result register frees the input side.
// Reset: every slot empty, rank equal to slot index, slots_in_use = 8, at once through one
// valid flop per layer row; no clearing pass. A clear beat resets the rows, not slots_in_use.
module lru_expert_slot_cache_unit
    import lesc_pkg::*;
#(
    parameter int LAYERS  = LAYERS_DEF,
    parameter int SLOTS   = SLOTS_DEF,
    parameter int EXPERTS = EXPERTS_DEF,
    localparam int LW = idx_w(LAYERS),
    localparam int SW = idx_w(SLOTS),
    localparam int EW = idx_w(EXPERTS),
    localparam int PADDR_W = 3,
    localparam int PDATA_W = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    op,
    input  logic [LW-1:0]      layer,
    input  logic [EW-1:0]      expert,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SW-1:0]      slot,
    output logic               hit,
    output logic               evicted_valid,
    output logic [EW-1:0]      evicted_expert
);

    localparam logic REG_SLOTS_IN_USE = 1'b0;

    logic [CFG_W-1:0] slots_in_use_reg;
    logic             reg_sel;
    lesc_cmd_t        cmd;
    lesc_stat_t       stat;

    // Register decode: word index is paddr[2]
    assign reg_sel = (paddr[PADDR_W-1] == REG_SLOTS_IN_USE);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= CFG_SLOTS_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            slots_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(PDATA_W - CFG_W){1'b0}}, slots_in_use_reg} : '0;

    lesc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lesc_dpath #(
        .LAYERS  (LAYERS),
        .SLOTS   (SLOTS),
        .EXPERTS (EXPERTS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .layer          (layer),
        .expert         (expert),
        .slots_in_use   (slots_in_use_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot           (slot),
        .hit            (hit),
        .evicted_valid  (evicted_valid),
        .evicted_expert (evicted_expert)
    );

endmodule

>>> src/lesc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lesc_ram
    import lesc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = idx_w(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lesc_ctrl.sv
// Controller FSM: fetch the layer row, then commit the result.
module lesc_ctrl
    import lesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lesc_stat_t stat,
    output lesc_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands
    assign in_ready    = (state_reg == ST_IDLE);
    assign cmd.capture = in_valid && (state_reg == ST_IDLE);
    assign cmd.commit  = (state_reg == ST_EXEC) && stat.out_free;

endmodule

>>> src/lesc_dpath.sv
// Datapath: layer row store, hit search, LRU victim pick, rank update.
module lesc_dpath
    import lesc_pkg::*;
#(
    parameter int LAYERS  = LAYERS_DEF,
    parameter int SLOTS   = SLOTS_DEF,
    parameter int EXPERTS = EXPERTS_DEF,
    localparam int LW = idx_w(LAYERS),
    localparam int SW = idx_w(SLOTS),
    localparam int EW = idx_w(EXPERTS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lesc_cmd_t        cmd,
    output lesc_stat_t       stat,
    input  logic [OP_W-1:0]  op,
    input  logic [LW-1:0]    layer,
    input  logic [EW-1:0]    expert,
    input  logic [CFG_W-1:0] slots_in_use,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SW-1:0]    slot,
    output logic             hit,
    output logic             evicted_valid,
    output logic [EW-1:0]    evicted_expert
);

    localparam int CW    = $clog2(SLOTS + 1);
    localparam int ENT_W = 1 + EW + SW;
    localparam int ROW_W = SLOTS * ENT_W;

    typedef struct packed {
        logic          vld;
        logic [EW-1:0] id;
        logic [SW-1:0] rank;
    } ent_t;

    typedef ent_t [SLOTS-1:0] row_t;

    // Latched request
    op_code_t      op_reg;
    logic [LW-1:0] layer_reg;
    logic [EW-1:0] expert_reg;
    logic          layer_ok_reg;

    // Row validity, one flop per layer
    logic [LAYERS-1:0] row_valid_reg;

    // Result register
    logic          out_valid_reg;
    logic [SW-1:0] slot_reg;
    logic          hit_reg;
    logic          ev_valid_reg;
    logic [EW-1:0] ev_expert_reg;

    logic [ROW_W-1:0] rd_data;
    logic             ram_we;
    row_t             dflt_row;
    row_t             cur_row;
    row_t             new_row;
    logic [CW-1:0]    k_eff;
    logic [SLOTS-1:0] used;
    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] is_max;
    logic [SW-1:0]    found;
    logic [SW-1:0]    victim;
    logic [SW-1:0]    tgt;
    logic [SW-1:0]    tgt_rank;
    logic             any_hit;
    logic [SW-1:0]    res_slot;
    logic             res_hit;
    logic             res_ev_valid;
    logic [EW-1:0]    res_ev_expert;

    // Capture request beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= op;
            layer_reg    <= layer;
            expert_reg   <= expert;
            layer_ok_reg <= ({1'b0, layer} < (LW + 1)'(LAYERS));
        end
    end

    // Row store
    lesc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (LAYERS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (layer_reg),
        .wdata (new_row),
        .re    (cmd.capture),
        .raddr (layer),
        .rdata (rd_data)
    );

    // Start-order row: all empty, rank equals slot index
    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            dflt_row[s].vld  = 1'b0;
            dflt_row[s].id   = '0;
            dflt_row[s].rank = SW'(s);
        end
    end

    assign cur_row = row_valid_reg[layer_reg] ? row_t'(rd_data) : dflt_row;

    // Effective slot count, clamped to 1..SLOTS
    always_comb
    begin
        if (slots_in_use == '0)
        begin
            k_eff = CW'(1);
        end
        else if (32'(slots_in_use) > 32'(SLOTS))
        begin
            k_eff = CW'(SLOTS);
        end
        else
        begin
            k_eff = CW'(slots_in_use);
        end
    end

    // Hit search, lowest matching slot wins
    always_comb
    begin
        found = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            used[s]  = (s < int'(k_eff));
            match[s] = used[s] && cur_row[s].vld && (cur_row[s].id == expert_reg);
        end
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (match[s])
            begin
                found = SW'(s);
            end
        end
    end

    assign any_hit = |match;

    // Victim: used slot with the oldest rank (ranks are distinct)
    always_comb
    begin
        victim = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            is_max[s] = used[s];
            for (int t = 0; t < SLOTS; t++)
            begin
                if (used[t] && (cur_row[t].rank > cur_row[s].rank))
                begin
                    is_max[s] = 1'b0;
                end
            end
        end
        for (int s = 0; s < SLOTS; s++)
        begin
            if (is_max[s])
            begin
                victim = SW'(s);
            end
        end
    end

    // Touch target and updated row
    assign tgt      = any_hit ? found : victim;
    assign tgt_rank = cur_row[tgt].rank;

    always_comb
    begin
        new_row = cur_row;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i == int'(tgt))
            begin
                new_row[i].rank = '0;
            end
            else if (cur_row[i].rank < tgt_rank)
            begin
                new_row[i].rank = cur_row[i].rank + 1'b1;
            end
        end
        if (!any_hit)
        begin
            new_row[victim].vld = 1'b1;
            new_row[victim].id  = expert_reg;
        end
    end

    assign ram_we = cmd.commit && (op_reg == OP_ACCESS) && layer_ok_reg;

    // Result fields; clear, unused code, bad layer and a peek miss give all zero
    always_comb
    begin
        res_slot      = '0;
        res_hit       = 1'b0;
        res_ev_valid  = 1'b0;
        res_ev_expert = '0;
        if (layer_ok_reg && ((op_reg == OP_ACCESS) || (op_reg == OP_PEEK)))
        begin
            if (any_hit)
            begin
                res_slot = found;
                res_hit  = 1'b1;
            end
            else if (op_reg == OP_ACCESS)
            begin
                res_slot     = victim;
                res_ev_valid = cur_row[victim].vld;
                if (cur_row[victim].vld)
                begin
                    res_ev_expert = cur_row[victim].id;
                end
            end
        end
    end

    // Row validity: clear drops all rows, a write marks its row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.commit && (op_reg == OP_CLEAR))
        begin
            row_valid_reg <= '0;
        end
        else if (ram_we)
        begin
            row_valid_reg[layer_reg] <= 1'b1;
        end
    end

    // Result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            slot_reg      <= res_slot;
            hit_reg       <= res_hit;
            ev_valid_reg  <= res_ev_valid;
            ev_expert_reg <= res_ev_expert;
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign slot           = slot_reg;
    assign hit            = hit_reg;
    assign evicted_valid  = ev_valid_reg;
    assign evicted_expert = ev_expert_reg;

endmodule

>>> src/lesc_checker.sv
// Port-level checker of the expert slot cache and its bind.
`include "lru_expert_slot_cache_unit_assert.svh"

module lesc_checker
    import lesc_pkg::*;
#(
    parameter int LAYERS  = LAYERS_DEF,
    parameter int SLOTS   = SLOTS_DEF,
    parameter int EXPERTS = EXPERTS_DEF,
    localparam int LW = idx_w(LAYERS),
    localparam int SW = idx_w(SLOTS),
    localparam int EW = idx_w(EXPERTS)
)
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic [OP_W-1:0] op,
    input logic [LW-1:0]   layer,
    input logic [EW-1:0]   expert,
    input logic            out_valid,
    input logic            out_ready,
    input logic [SW-1:0]   slot,
    input logic            hit,
    input logic            evicted_valid,
    input logic [EW-1:0]   evicted_expert
);

    // One request in flight: ready drops after an accepted beat
    `LESC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // A waiting request beat holds its payload
    `LESC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(op) && $stable(layer) && $stable(expert))

    // A stalled result beat holds its payload
    `LESC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(slot) && $stable(hit) && $stable(evicted_valid) && $stable(evicted_expert))

    // A hit never evicts
    `LESC_ASSERT_SAME(a_hit_no_evict, clk, rst_n, out_valid && hit, !evicted_valid)

    // No eviction reports expert zero
    `LESC_ASSERT_SAME(a_evict_zero, clk, rst_n, out_valid && !evicted_valid, evicted_expert == '0)

endmodule

bind lru_expert_slot_cache_unit lesc_checker #(
    .LAYERS  (LAYERS),
    .SLOTS   (SLOTS),
    .EXPERTS (EXPERTS)
) u_lesc_checker (.*);

>>> test/lru_expert_slot_cache_unit_tb.sv
// Testbench for lru_expert_slot_cache_unit: random and directed requests checked against an LRU pool model.
`timescale 1ns / 1ps

module lru_expert_slot_cache_unit_tb;
    import lesc_pkg::*;

    localparam int LAYERS  = LAYERS_DEF;
    localparam int SLOTS   = SLOTS_DEF;
    localparam int LW      = idx_w(LAYERS_DEF);
    localparam int SW      = idx_w(SLOTS_DEF);
    localparam int EW      = idx_w(EXPERTS_DEF);
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam op_code_t OP_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_SLOTS_IN_USE = 3'd0;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 240;

    typedef struct {
        op_code_t        code;
        logic [LW-1:0]   lyr;
        logic [EW-1:0]   exp_id;
        int unsigned     gap;
    } request_t;

    typedef struct {
        logic [SW-1:0]   slot;
        logic            hit;
        logic            ev_valid;
        logic [EW-1:0]   ev_expert;
    } lookup_t;

    // DUT ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    op = '0;
    logic [LW-1:0]      layer = '0;
    logic [EW-1:0]      expert = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [SW-1:0]      slot;
    logic               hit;
    logic               evicted_valid;
    logic [EW-1:0]      evicted_expert;

    // Stimulus and scoreboard state
    request_t    req_q[$];
    lookup_t     pending_results[$];
    int unsigned queued_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned error_cnt = 0;
    bit          calm = 1'b0;
    int unsigned hold_asks = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned pause = 0;
    int unsigned wait_left = 0;
    bit          gap_taken = 1'b0;
    bit          in_beat = 1'b0;
    bit          out_beat = 1'b0;

    // Pool model: owner per slot and recency rank (0 = most recent)
    bit            owner_ok [LAYERS][SLOTS];
    bit [EW-1:0]   owner_id [LAYERS][SLOTS];
    bit [SW-1:0]   rank_of  [LAYERS][SLOTS];
    bit [CFG_W-1:0] slots_cfg = CFG_SLOTS_RESET;

    lru_expert_slot_cache_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .layer(layer), .expert(expert),
        .out_valid(out_valid), .out_ready(out_ready),
        .slot(slot), .hit(hit), .evicted_valid(evicted_valid),
        .evicted_expert(evicted_expert)
    );

    // Clock and reset
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void restore_pools();
        for (int l = 0; l < LAYERS; l++)
            for (int s = 0; s < SLOTS; s++)
            begin
                owner_ok[l][s] = 1'b0;
                owner_id[l][s] = '0;
                rank_of[l][s]  = SW'(s);
            end
    endfunction

    // Make slot s of layer l the most recent; younger slots age by one
    function automatic void promote(int l, int s);
        bit [SW-1:0] r;
        r = rank_of[l][s];
        for (int i = 0; i < SLOTS; i++)
            if (rank_of[l][i] < r)
                rank_of[l][i] = rank_of[l][i] + 1'b1;
        rank_of[l][s] = '0;
    endfunction

    // Expected result of one request beat, updating the pool model
    function automatic lookup_t cache_step(op_code_t code, logic [LW-1:0] l, logic [EW-1:0] e);
        lookup_t res;
        int      used;
        int      found;
        int      victim;
        res = '{slot: '0, hit: 1'b0, ev_valid: 1'b0, ev_expert: '0};
        if (code == OP_CLEAR)
        begin
            restore_pools();
            return res;
        end
        if (code == OP_UNUSED || int'(l) >= LAYERS)
            return res;
        used = (slots_cfg == 0) ? 1 : ((int'(slots_cfg) > SLOTS) ? SLOTS : int'(slots_cfg));
        found = -1;
        for (int s = 0; s < used; s++)
            if (found < 0 && owner_ok[l][s] && owner_id[l][s] == e)
                found = s;
        if (found >= 0)
        begin
            if (code == OP_ACCESS)
                promote(l, found);
            res.slot = SW'(found);
            res.hit  = 1'b1;
            return res;
        end
        if (code == OP_PEEK)
            return res;
        // Miss: evict the oldest used slot
        victim = 0;
        for (int s = 1; s < used; s++)
            if (rank_of[l][s] > rank_of[l][victim])
                victim = s;
        if (owner_ok[l][victim])
        begin
            res.ev_valid  = 1'b1;
            res.ev_expert = owner_id[l][victim];
        end
        owner_ok[l][victim] = 1'b1;
        owner_id[l][victim] = e;
        promote(l, victim);
        res.slot = SW'(victim);
        return res;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_cnt++;
    endtask

    // Request driver
    always @(negedge clk)
    begin
        if (!in_valid || in_beat)
        begin
            if (wait_left > 0)
            begin
                in_valid  <= 1'b0;
                wait_left <= wait_left - 1;
            end
            else if (req_q.size() > 0 && req_q[0].gap > 0 && !gap_taken)
            begin
                in_valid  <= 1'b0;
                wait_left <= req_q[0].gap - 1;
                gap_taken <= 1'b1;
            end
            else if (req_q.size() > 0)
            begin
                op        <= req_q[0].code;
                layer     <= req_q[0].lyr;
                expert    <= req_q[0].exp_id;
                in_valid  <= 1'b1;
                gap_taken <= 1'b0;
                void'(req_q.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus long holds on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_served)
        begin
            out_ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= hold_served + 1;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (out_beat && !calm)
        begin
            pause = $urandom_range(0, 11);
            if (pause > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= pause - 1;
            end
            else
                out_ready <= 1'b1;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: predict on request beats, check on result beats
    always @(posedge clk)
    begin
        lookup_t want;
        in_beat  <= in_valid && in_ready;
        out_beat <= out_valid && out_ready;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_SLOTS_IN_USE)
                slots_cfg = pwdata[CFG_W-1:0];
            if (in_valid && in_ready)
            begin
                pending_results = {pending_results, cache_step(op, layer, expert)};
                accepted_cnt++;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("[%0t] result beat with nothing outstanding", $time);
                    error_cnt++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (slot !== want.slot)
                        flag_mismatch("slot", slot, want.slot);
                    if (hit !== want.hit)
                        flag_mismatch("hit", hit, want.hit);
                    if (evicted_valid !== want.ev_valid)
                        flag_mismatch("evicted_valid", evicted_valid, want.ev_valid);
                    if (evicted_expert !== want.ev_expert)
                        flag_mismatch("evicted_expert", evicted_expert, want.ev_expert);
                end
            end
        end
    end

    task automatic add_request(op_code_t code, int l, int e);
        request_t r;
        r.code   = code;
        r.lyr    = LW'(l);
        r.exp_id = EW'(e);
        r.gap    = calm ? 0 : $urandom_range(0, 11);
        req_q = {req_q, r};
        queued_cnt++;
    endtask

    task automatic add_random_request();
        int unsigned pick;
        op_code_t    code;
        int          l;
        int          e;
        pick = $urandom_range(0, 99);
        if (pick < 68)
            code = OP_ACCESS;
        else if (pick < 93)
            code = OP_PEEK;
        else if (pick < 96)
            code = OP_UNUSED;
        else
            code = OP_CLEAR;
        // Mostly a few layers and a small expert set so pools fill, hit and evict
        l = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(0, LAYERS - 1);
        e = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 11) : $urandom_range(0, 63);
        add_request(code, l, e);
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write then read back, both as setup + access
    task automatic write_slots_in_use(logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SLOTS_IN_USE;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[CFG_W-1:0] !== value)
            flag_mismatch("slots_in_use readback", prdata[CFG_W-1:0], value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        logic [CFG_W-1:0] cfg_val;
        restore_pools();
        wait (rst_n);
        @(posedge clk);

        // Directed: clear, unused op, fill and evict in the top layer, hits, peeks
        add_request(OP_CLEAR, 0, 0);
        add_request(OP_UNUSED, 15, 63);
        for (int k = 0; k < 9; k++)
            add_request(OP_ACCESS, 15, 63 - k);
        add_request(OP_ACCESS, 15, 62);
        add_request(OP_PEEK, 15, 61);
        add_request(OP_PEEK, 15, 63);
        add_request(OP_ACCESS, 0, 0);
        add_request(OP_ACCESS, 0, 0);
        add_request(OP_PEEK, 0, 5);
        add_request(OP_CLEAR, 15, 63);
        add_request(OP_ACCESS, 15, 61);
        add_request(OP_UNUSED, 0, 0);
        add_request(OP_ACCESS, 7, 42);
        add_request(OP_PEEK, 7, 42);
        wait_drained();

        // Random phases over several pool sizes, clamped values included
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: cfg_val = 4'd1;
                1: cfg_val = 4'd15;
                2: cfg_val = 4'd0;
                3: cfg_val = 4'd2;
                4: cfg_val = 4'd8;
                5: cfg_val = 4'd3;
                default: cfg_val = CFG_W'($urandom_range(0, 15));
            endcase
            write_slots_in_use(cfg_val);
            calm = (p % 3 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                add_random_request();
            // Long result hold while requests keep coming
            if (p == 1 || p == 4)
                hold_asks++;
            wait_drained();
        end
        calm = 1'b0;

        repeat (10) @(posedge clk);
        if (error_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> lru_expert_slot_cache_unit.f
+incdir+src
src/lesc_pkg.sv
src/lesc_ram.sv
src/lesc_ctrl.sv
src/lesc_dpath.sv
src/lru_expert_slot_cache_unit.sv
src/lesc_checker.sv
test/lru_expert_slot_cache_unit_tb.sv
